### rtl/core/line_near_clip_and_viewport_project_defines.svh
// Assertion macros used by the verification code of the line clip and projection block.
`ifndef LINE_NEAR_CLIP_AND_VIEWPORT_PROJECT_DEFINES_SVH
`define LINE_NEAR_CLIP_AND_VIEWPORT_PROJECT_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define LNC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define LNC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lnc_pkg.sv
// Shared constants and the segment word type of the line clip and projection block.
`timescale 1ns / 1ps
`default_nettype none

package lnc_pkg;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int RW = 14;
	localparam int CLRW = 32;
	localparam int CFG_IW = 2;
	localparam int NEAR_W = ((1 << FB) + 9999) / 10000;
	localparam int QD = 4;
	localparam int QAW = $clog2(QD);
	localparam int VP_LEFT_RST = 0;
	localparam int VP_TOP_RST = 0;
	localparam int VP_WIDTH_RST = 1920;
	localparam int VP_HEIGHT_RST = 1080;

	typedef enum logic [CFG_IW-1:0] {
		CFG_LEFT,
		CFG_TOP,
		CFG_WIDTH,
		CFG_HEIGHT
	} cfg_idx_t;

	typedef struct packed {
		logic visible;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] aw;
		logic [CW-1:0] bx;
		logic [CW-1:0] by;
		logic [CW-1:0] bw;
		logic [CLRW-1:0] color;
	} line_t;

endpackage

`default_nettype wire

### rtl/core/line_near_clip_and_viewport_project.sv
// Line segment near-plane clip and viewport projection, top level.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one line segment per word, as two clip-space endpoints in
// signed Q16.16 plus a color, and returns one result word for each. A segment
// whose two w values are both at or below the near threshold (7 codes) is
// dropped; a segment with one end behind has that end moved onto the plane
// w = threshold. Both ends are then divided by w and mapped into the viewport
// in pixels with y pointing down, saturated to signed 32 bits. A dropped
// segment comes out with line_visible low and zero coordinates; the color is
// always passed through. The block takes one word per clock when nothing
// stalls. Each word passes through the clip front end (one subtract stage,
// one multiply stage, 32 steps of the interpolation divider), the four-word
// queue, and the projection back end (magnitude stage, multiply stage, 33
// steps of the perspective divider, one lane per coordinate, output
// register). The queue lets the front end keep taking words while the
// output side is stalled for up to four words. Viewport registers are
// written through cfg_we, cfg_index and cfg_data, take effect at once, and
// should be changed only while no word is in flight.
module line_near_clip_and_viewport_project (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [lnc_pkg::CW-1:0] start_clip_x,
	input  logic signed [lnc_pkg::CW-1:0] start_clip_y,
	input  logic signed [lnc_pkg::CW-1:0] start_clip_w,
	input  logic signed [lnc_pkg::CW-1:0] end_clip_x,
	input  logic signed [lnc_pkg::CW-1:0] end_clip_y,
	input  logic signed [lnc_pkg::CW-1:0] end_clip_w,
	input  logic [lnc_pkg::CLRW-1:0]      line_color,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_visible,
	output logic signed [lnc_pkg::CW-1:0] start_screen_x,
	output logic signed [lnc_pkg::CW-1:0] start_screen_y,
	output logic signed [lnc_pkg::CW-1:0] end_screen_x,
	output logic signed [lnc_pkg::CW-1:0] end_screen_y,
	output logic [lnc_pkg::CLRW-1:0]      color_out,
	input  logic                          cfg_we,
	input  logic [lnc_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [lnc_pkg::RW-1:0]        cfg_data
);

	localparam int RW = lnc_pkg::RW;

	logic [RW-1:0] vp_left_q;
	logic [RW-1:0] vp_top_q;
	logic [RW-1:0] vp_width_q;
	logic [RW-1:0] vp_height_q;

	lnc_pkg::line_t seg;
	lnc_pkg::line_t push_word;
	lnc_pkg::line_t pop_word;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	// Viewport registers; every index in the port's range names a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_left_q <= RW'(lnc_pkg::VP_LEFT_RST);
			vp_top_q <= RW'(lnc_pkg::VP_TOP_RST);
			vp_width_q <= RW'(lnc_pkg::VP_WIDTH_RST);
			vp_height_q <= RW'(lnc_pkg::VP_HEIGHT_RST);
		end else if (cfg_we) begin
			unique case (lnc_pkg::cfg_idx_t'(cfg_index))
				lnc_pkg::CFG_LEFT: vp_left_q <= cfg_data;
				lnc_pkg::CFG_TOP: vp_top_q <= cfg_data;
				lnc_pkg::CFG_WIDTH: vp_width_q <= cfg_data;
				lnc_pkg::CFG_HEIGHT: vp_height_q <= cfg_data;
			endcase
		end
	end

	// The visible flag is decided in the front end; it enters set.
	always_comb begin
		seg.visible = 1'b1;
		seg.ax = start_clip_x;
		seg.ay = start_clip_y;
		seg.aw = start_clip_w;
		seg.bx = end_clip_x;
		seg.by = end_clip_y;
		seg.bw = end_clip_w;
		seg.color = line_color;
	end

	lnc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.seg        (seg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	lnc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	lnc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_word       (pop_word),
		.vp_left        (vp_left_q),
		.vp_top         (vp_top_q),
		.vp_width       (vp_width_q),
		.vp_height      (vp_height_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.line_visible   (line_visible),
		.start_screen_x (start_screen_x),
		.start_screen_y (start_screen_y),
		.end_screen_x   (end_screen_x),
		.end_screen_y   (end_screen_y),
		.color_out      (color_out)
	);

endmodule

`default_nettype wire

### rtl/core/lnc_front.sv
// Front end: near-plane classification and pipelined clipping of one endpoint.
`timescale 1ns / 1ps
`default_nettype none

module lnc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lnc_pkg::line_t  seg,
	output logic            push_valid,
	input  logic            push_ready,
	output lnc_pkg::line_t  push_word
);

	localparam int CW = lnc_pkg::CW;
	localparam logic signed [CW-1:0] NEAR = CW'(lnc_pkg::NEAR_W);

	typedef struct packed {
		lnc_pkg::line_t ln;
		logic clip_a;
		logic clip_b;
		logic xneg;
		logic yneg;
		logic [CW-1:0] n;
		logic [CW-1:0] d;
		logic [CW-1:0] xr;
		logic [CW-1:0] xq;
		logic [CW-1:0] yr;
		logic [CW-1:0] yq;
	} lerp_t;

	// One restoring division step on both lanes; the quotient shifts in at the bottom.
	function automatic lerp_t lerp_div(input lerp_t i);
		lerp_t o;
		logic [CW:0] rx;
		logic [CW:0] ry;
		logic gx;
		logic gy;
		o = i;
		rx = {i.xr, i.xq[CW-1]};
		ry = {i.yr, i.yq[CW-1]};
		gx = rx >= {1'b0, i.d};
		gy = ry >= {1'b0, i.d};
		if (gx) rx = rx - {1'b0, i.d};
		if (gy) ry = ry - {1'b0, i.d};
		o.xr = rx[CW-1:0];
		o.yr = ry[CW-1:0];
		o.xq = {i.xq[CW-2:0], gx};
		o.yq = {i.yq[CW-2:0], gy};
		return o;
	endfunction

	logic en;
	logic vld_s1;
	logic vld_s2;
	logic [CW-1:0] dv_vld_s;
	lerp_t s1_d;
	lerp_t s2_d;
	lerp_t lerp_s1;
	lerp_t lerp_s2;
	lerp_t dv_s [CW];

	logic a_beh;
	logic b_beh;
	logic signed [CW:0] den;
	logic signed [CW:0] num;
	logic signed [CW:0] dpos;
	logic signed [CW:0] npos;
	logic signed [CW:0] dx;
	logic signed [CW:0] dy;
	logic signed [CW:0] ndx;
	logic signed [CW:0] ndy;
	logic [2*CW-1:0] px;
	logic [2*CW-1:0] py;
	logic [CW-1:0] cx;
	logic [CW-1:0] cy;

	assign en = ~dv_vld_s[CW-1] | push_ready;
	assign in_ready = en;
	assign push_valid = dv_vld_s[CW-1];

	always_comb begin
		a_beh = $signed(seg.aw) <= NEAR;
		b_beh = $signed(seg.bw) <= NEAR;
		den = $signed({seg.bw[CW-1], seg.bw}) - $signed({seg.aw[CW-1], seg.aw});
		num = $signed({NEAR[CW-1], NEAR}) - $signed({seg.aw[CW-1], seg.aw});
		if (den[CW]) begin
			dpos = -den;
			npos = -num;
		end else begin
			dpos = den;
			npos = num;
		end
		dx = $signed({seg.bx[CW-1], seg.bx}) - $signed({seg.ax[CW-1], seg.ax});
		dy = $signed({seg.by[CW-1], seg.by}) - $signed({seg.ay[CW-1], seg.ay});
		ndx = -dx;
		ndy = -dy;
		s1_d = '0;
		s1_d.ln = seg;
		s1_d.ln.visible = ~((a_beh & b_beh) | ((a_beh ^ b_beh) & (den == '0)));
		s1_d.clip_a = a_beh & ~b_beh;
		s1_d.clip_b = b_beh & ~a_beh;
		s1_d.d = dpos[CW-1:0];
		if (npos[CW]) begin
			s1_d.n = '0;
		end else if (npos > dpos) begin
			s1_d.n = dpos[CW-1:0];
		end else begin
			s1_d.n = npos[CW-1:0];
		end
		s1_d.xneg = dx[CW];
		s1_d.yneg = dy[CW];
		s1_d.xq = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
		s1_d.yq = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
	end

	// The product's high half is below d whenever the clamp holds, so the
	// quotient takes exactly CW steps.
	assign px = lerp_s1.xq * lerp_s1.n;
	assign py = lerp_s1.yq * lerp_s1.n;

	always_comb begin
		s2_d = lerp_s1;
		s2_d.xr = px[2*CW-1:CW];
		s2_d.xq = px[CW-1:0];
		s2_d.yr = py[2*CW-1:CW];
		s2_d.yq = py[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dv_vld_s <= '0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			dv_vld_s <= {dv_vld_s[CW-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lerp_s1 <= s1_d;
			lerp_s2 <= s2_d;
			dv_s[0] <= lerp_div(lerp_s2);
			for (int k = 1; k < CW; k++) begin
				dv_s[k] <= lerp_div(dv_s[k-1]);
			end
		end
	end

	always_comb begin
		cx = dv_s[CW-1].xneg ? dv_s[CW-1].ln.ax - dv_s[CW-1].xq
			: dv_s[CW-1].ln.ax + dv_s[CW-1].xq;
		cy = dv_s[CW-1].yneg ? dv_s[CW-1].ln.ay - dv_s[CW-1].yq
			: dv_s[CW-1].ln.ay + dv_s[CW-1].yq;
		push_word = dv_s[CW-1].ln;
		if (dv_s[CW-1].clip_a) begin
			push_word.ax = cx;
			push_word.ay = cy;
			push_word.aw = NEAR;
		end
		if (dv_s[CW-1].clip_b) begin
			push_word.bx = cx;
			push_word.by = cy;
			push_word.bw = NEAR;
		end
	end

endmodule

`default_nettype wire

### rtl/core/lnc_queue.sv
// Small word queue between the clipping front end and the projection back end.
`timescale 1ns / 1ps
`default_nettype none

module lnc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lnc_pkg::line_t  push_word,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lnc_pkg::line_t  pop_word
);

	localparam int QAW = lnc_pkg::QAW;

	lnc_pkg::line_t mem_q [lnc_pkg::QD];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != (QAW+1)'(lnc_pkg::QD);
	assign pop_valid = cnt_q != '0;
	assign do_push = push_valid & push_ready;
	assign do_pop = pop_valid & pop_ready;
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + (QAW+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_word;
	end

endmodule

`default_nettype wire

### rtl/core/lnc_back.sv
// Back end: pipelined perspective divide, viewport mapping and saturation.
`timescale 1ns / 1ps
`default_nettype none

module lnc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  lnc_pkg::line_t                pop_word,
	input  logic [lnc_pkg::RW-1:0]        vp_left,
	input  logic [lnc_pkg::RW-1:0]        vp_top,
	input  logic [lnc_pkg::RW-1:0]        vp_width,
	input  logic [lnc_pkg::RW-1:0]        vp_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_visible,
	output logic signed [lnc_pkg::CW-1:0] start_screen_x,
	output logic signed [lnc_pkg::CW-1:0] start_screen_y,
	output logic signed [lnc_pkg::CW-1:0] end_screen_x,
	output logic signed [lnc_pkg::CW-1:0] end_screen_y,
	output logic [lnc_pkg::CLRW-1:0]      color_out
);

	localparam int CW = lnc_pkg::CW;
	localparam int FB = lnc_pkg::FB;
	localparam int RW = lnc_pkg::RW;
	localparam int QW = CW + 1;
	localparam int PW = CW + RW + FB - 1;
	localparam int SW = ((CW > RW + FB) ? CW : RW + FB) + 3;
	localparam logic [QW-1:0] CAP = {1'b1, {CW{1'b0}}};
	localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	typedef struct packed {
		logic neg;
		logic ovf;
		logic [CW-2:0] w;
		logic [CW-2:0] rem;
		logic [QW-1:0] lq;
	} lane_t;

	typedef struct packed {
		logic visible;
		logic [lnc_pkg::CLRW-1:0] color;
		lane_t [3:0] lane;
	} bk_t;

	function automatic lane_t proj_div(input lane_t l);
		lane_t o;
		logic [CW-1:0] r;
		logic ge;
		o = l;
		r = {l.rem, l.lq[QW-1]};
		ge = r >= {1'b0, l.w};
		if (ge) r = r - {1'b0, l.w};
		o.rem = r[CW-2:0];
		o.lq = {l.lq[QW-2:0], ge};
		return o;
	endfunction

	function automatic bk_t bk_div(input bk_t b);
		bk_t o;
		o = b;
		for (int i = 0; i < 4; i++) begin
			o.lane[i] = proj_div(b.lane[i]);
		end
		return o;
	endfunction

	logic en;
	logic vld_s1;
	logic vld_s2;
	logic [QW-1:0] dv_vld_s;
	bk_t p1_d;
	bk_t p2_d;
	bk_t bk_s1;
	bk_t bk_s2;
	bk_t dv_s [QW];
	logic [CW-1:0] cc [4];
	logic [CW-1:0] ww [4];
	logic [CW-1:0] mg [4];
	logic [CW+RW-1:0] m [4];
	logic [PW-1:0] prod [4];
	logic [QW-1:0] offv [4];
	logic signed [SW-1:0] base [4];
	logic signed [SW-1:0] sum [4];
	logic [CW-1:0] res [4];

	logic out_valid_q;
	logic visible_q;
	logic [CW-1:0] sx0_q;
	logic [CW-1:0] sy0_q;
	logic [CW-1:0] sx1_q;
	logic [CW-1:0] sy1_q;
	logic [lnc_pkg::CLRW-1:0] color_q;

	assign en = ~out_valid_q | out_ready;
	assign pop_ready = en;

	always_comb begin
		cc[0] = pop_word.ax;
		cc[1] = pop_word.ay;
		cc[2] = pop_word.bx;
		cc[3] = pop_word.by;
		ww[0] = pop_word.aw;
		ww[1] = pop_word.aw;
		ww[2] = pop_word.bw;
		ww[3] = pop_word.bw;
		p1_d = '0;
		p1_d.visible = pop_word.visible;
		p1_d.color = pop_word.color;
		for (int i = 0; i < 4; i++) begin
			mg[i] = cc[i][CW-1] ? (~cc[i] + CW'(1)) : cc[i];
			// Screen y grows downward, so the y lanes take the opposite sign.
			p1_d.lane[i].neg = cc[i][CW-1] ^ ((i == 1) || (i == 3));
			p1_d.lane[i].w = ww[i][CW-2:0];
			p1_d.lane[i].lq = QW'(mg[i]);
		end
	end

	always_comb begin
		p2_d = bk_s1;
		for (int i = 0; i < 4; i++) begin
			m[i] = bk_s1.lane[i].lq[CW-1:0] * (((i == 1) || (i == 3)) ? vp_height : vp_width);
			prod[i] = {m[i], {(FB-1){1'b0}}};
			p2_d.lane[i].ovf = (prod[i] >> QW) >= PW'(bk_s1.lane[i].w);
			p2_d.lane[i].rem = (CW-1)'(prod[i] >> QW);
			p2_d.lane[i].lq = prod[i][QW-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			offv[i] = (dv_s[QW-1].lane[i].ovf || (dv_s[QW-1].lane[i].lq > CAP))
				? CAP : dv_s[QW-1].lane[i].lq;
			if ((i == 1) || (i == 3)) begin
				base[i] = SW'({vp_top, {FB{1'b0}}}) + SW'({vp_height, {(FB-1){1'b0}}});
			end else begin
				base[i] = SW'({vp_left, {FB{1'b0}}}) + SW'({vp_width, {(FB-1){1'b0}}});
			end
			sum[i] = dv_s[QW-1].lane[i].neg ? base[i] - $signed(SW'(offv[i]))
				: base[i] + $signed(SW'(offv[i]));
			if (sum[i] > SMAX) begin
				res[i] = SMAX[CW-1:0];
			end else if (sum[i] < SMIN) begin
				res[i] = SMIN[CW-1:0];
			end else begin
				res[i] = sum[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dv_vld_s <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop_valid;
			vld_s2 <= vld_s1;
			dv_vld_s <= {dv_vld_s[QW-2:0], vld_s2};
			out_valid_q <= dv_vld_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s1 <= p1_d;
			bk_s2 <= p2_d;
			dv_s[0] <= bk_div(bk_s2);
			for (int k = 1; k < QW; k++) begin
				dv_s[k] <= bk_div(dv_s[k-1]);
			end
			visible_q <= dv_s[QW-1].visible;
			color_q <= dv_s[QW-1].color;
			sx0_q <= dv_s[QW-1].visible ? res[0] : '0;
			sy0_q <= dv_s[QW-1].visible ? res[1] : '0;
			sx1_q <= dv_s[QW-1].visible ? res[2] : '0;
			sy1_q <= dv_s[QW-1].visible ? res[3] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign line_visible = visible_q;
	assign start_screen_x = $signed(sx0_q);
	assign start_screen_y = $signed(sy0_q);
	assign end_screen_x = $signed(sx1_q);
	assign end_screen_y = $signed(sy1_q);
	assign color_out = color_q;

endmodule

`default_nettype wire

### rtl/core/lnc_checker.sv
// Port-level checks for the line clip and projection block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "line_near_clip_and_viewport_project_defines.svh"

module lnc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          line_visible,
	input wire logic signed [lnc_pkg::CW-1:0] start_screen_x,
	input wire logic signed [lnc_pkg::CW-1:0] start_screen_y,
	input wire logic signed [lnc_pkg::CW-1:0] end_screen_x,
	input wire logic signed [lnc_pkg::CW-1:0] end_screen_y,
	input wire logic [lnc_pkg::CLRW-1:0]      color_out
);

	logic [7:0] pend_q;
	logic [4*lnc_pkg::CW+lnc_pkg::CLRW:0] out_word;
	logic in_acc;
	logic out_acc;

	assign in_acc = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;
	assign out_word = {line_visible, start_screen_x, start_screen_y, end_screen_x,
		end_screen_y, color_out};

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 8'd1;
		end
	end

	`LNC_ASSERT_NOW(a_no_phantom, out_valid, pend_q != 8'd0, "result word without a pending input")
	`LNC_ASSERT_NOW(a_drop_zero, out_valid && !line_visible, (start_screen_x == 0) && (start_screen_y == 0) && (end_screen_x == 0) && (end_screen_y == 0), "dropped segment has nonzero coordinates")
	`LNC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result word changed")

endmodule

bind line_near_clip_and_viewport_project lnc_checker u_lnc_checker (.*);

`default_nettype wire
